// ===== hw/rtl/pip_pkg.sv =====
// pip_pkg: shared constants and types for the point-in-polygon test block
// no dependencies; imported by every module under hw/rtl
package pip_pkg;

  // table geometry
  localparam int unsigned MaxVertices = 64;
  localparam int unsigned AddrW       = $clog2(MaxVertices);
  localparam int unsigned CountW      = AddrW + 1;
  localparam int unsigned CoordW      = 32;
  localparam int unsigned DiffW       = CoordW + 1;
  localparam int unsigned ProdW       = 2 * DiffW;
  localparam int unsigned EntryW      = 2 * CoordW;

  localparam logic [CountW-1:0] MaxCount = CountW'(MaxVertices);

  // input opcodes
  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  // sequencer to edge pipeline control
  typedef struct packed {
    logic clear;  // new query, reset parity
    logic vld;    // vertex read data valid this cycle
    logic prime;  // read data is the closing vertex, store only
  } pip_edge_ctrl_t;

  // edge pipeline status back to the sequencer
  typedef struct packed {
    logic busy;    // edges still in flight
    logic parity;  // crossing count parity so far
  } pip_edge_stat_t;

endpackage

// ===== hw/rtl/point_in_polygon_test.sv =====
// point_in_polygon_test: top level, query sequencer, config register, output register
// depends on pip_pkg, pip_vertex_ram and pip_edge_unit
//
// Even-odd point-in-polygon test over a table of up to 64 vertices in signed
// Q16.16. A vertex write (opcode 0) stores one vertex and gives no transaction
// on the output. A query (opcode 1) walks the edges from the vertex memory,
// one vertex read per cycle: the closing vertex first, then vertices 0 to
// n-1, where n is vertex_count saturated at 64. A query holds the input
// through accept, n + 1 memory reads, a drain for the read latency and the
// subtract/multiply/compare stages, and the load of the output register,
// plus any wait that a still stalled previous result adds. The single memory
// read port bounds the walk; with n = 0 a query goes straight to the output
// register and reports outside. One item is worked at a time; the next may be
// accepted while the previous result waits on the output register. The user
// must write vertex_count only while idle; the block itself does not enforce
// it. Reading a slot that was never written gives an undefined result.
module point_in_polygon_test
  import pip_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              opcode_i,
  input  logic [5:0]        vertex_index_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic              cfg_we_i,
  input  logic [6:0]        cfg_wdata_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              inside_flag_o
);

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StDrain,
    StDone
  } state_e;

  state_e              state_q;
  logic [CountW-1:0]   count_q;
  logic [CountW-1:0]   n_q;
  logic [CountW-1:0]   cnt_q;
  logic [CoordW-1:0]   px_q, py_q;
  logic                rd_vld_q, prime_q;
  logic                out_valid_q, inside_q;

  logic                in_acc, is_query;
  logic [CountW-1:0]   n_sat;
  logic                rd_en;
  logic [CountW-1:0]   rd_idx;
  logic [EntryW-1:0]   rd_data;
  logic                out_free;
  logic                out_load;
  pip_edge_ctrl_t      edge_ctrl;
  pip_edge_stat_t      edge_stat;

  // input handshake
  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && (state_q == StIdle);
  assign is_query   = (opcode_i == OpQuery);
  assign n_sat      = (count_q > MaxCount) ? MaxCount : count_q;

  // read address: closing vertex first, then 0 .. n-1
  assign rd_en  = (state_q == StWalk);
  assign rd_idx = (cnt_q == '0) ? (n_q - CountW'(1)) : (cnt_q - CountW'(1));

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == StDone) && out_free;

  // vertex memory
  pip_vertex_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && (opcode_i == OpWrite)),
    .waddr_i (vertex_index_i[AddrW-1:0]),
    .wdata_i ({coord_x_i[CoordW-1:0], coord_y_i[CoordW-1:0]}),
    .re_i    (rd_en),
    .raddr_i (rd_idx[AddrW-1:0]),
    .rdata_o (rd_data)
  );

  // edge pipeline
  assign edge_ctrl.clear = in_acc && is_query;
  assign edge_ctrl.vld   = rd_vld_q;
  assign edge_ctrl.prime = prime_q;

  pip_edge_unit u_edge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (edge_ctrl),
    .vertex_i (rd_data),
    .px_i     (px_q),
    .py_i     (py_q),
    .stat_o   (edge_stat)
  );

  // query point capture
  always_ff @(posedge clk_i) begin
    if (in_acc && is_query) begin
      px_q <= coord_x_i[CoordW-1:0];
      py_q <= coord_y_i[CoordW-1:0];
    end
  end

  // sequencer, config register and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      prime_q     <= 1'b0;
      out_valid_q <= 1'b0;
      inside_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      rd_vld_q <= rd_en;
      prime_q  <= rd_en && (cnt_q == '0);
      // output register: load a finished query, drop a transaction once taken
      if (out_load) begin
        out_valid_q <= 1'b1;
        inside_q    <= edge_stat.parity;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc && is_query) begin
            n_q   <= n_sat;
            cnt_q <= '0;
            state_q <= (n_sat == '0) ? StDone : StWalk;
          end
        end
        StWalk: begin
          cnt_q <= cnt_q + CountW'(1);
          if (cnt_q == n_q) begin
            state_q <= StDrain;
          end
        end
        StDrain: begin
          if (!rd_vld_q && !edge_stat.busy) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign inside_flag_o = inside_q;

endmodule

// ===== hw/rtl/pip_vertex_ram.sv =====
// pip_vertex_ram: vertex table, one write port, one read port, registered read
// depends on pip_pkg for depth and entry width
module pip_vertex_ram
  import pip_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [EntryW-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [EntryW-1:0] rdata_o
);

  logic [EntryW-1:0] mem_q [MaxVertices];
  logic [EntryW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/pip_edge_unit.sv =====
// pip_edge_unit: three-stage edge pipeline, one edge per cycle, crossing parity
// depends on pip_pkg for widths and the control/status structs
module pip_edge_unit
  import pip_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pip_edge_ctrl_t      ctrl_i,
  input  logic [EntryW-1:0]   vertex_i,
  input  logic [CoordW-1:0]   px_i,
  input  logic [CoordW-1:0]   py_i,
  output pip_edge_stat_t      stat_o
);

  // current vertex i from memory, previous vertex j held locally
  logic signed [CoordW-1:0] xi, yi, px, py;
  logic signed [CoordW-1:0] xj_q, yj_q;

  assign xi = vertex_i[EntryW-1:CoordW];
  assign yi = vertex_i[CoordW-1:0];
  assign px = px_i;
  assign py = py_i;

  // stage 1 differences and straddle test
  logic signed [DiffW-1:0] dxp_d, dy_d, dxe_d, dyp_d;
  logic                    straddle_d;
  logic signed [DiffW-1:0] s1_dxp_q, s1_dy_q, s1_dxe_q, s1_dyp_q;
  logic                    s1_vld_q;

  always_comb begin
    dxp_d      = {px[CoordW-1], px} - {xi[CoordW-1], xi};
    dy_d       = {yj_q[CoordW-1], yj_q} - {yi[CoordW-1], yi};
    dxe_d      = {xj_q[CoordW-1], xj_q} - {xi[CoordW-1], xi};
    dyp_d      = {py[CoordW-1], py} - {yi[CoordW-1], yi};
    straddle_d = (yi > py) != (yj_q > py);
  end

  // stage 2 cross products
  logic signed [ProdW-1:0] lhs_d, rhs_d;
  logic signed [ProdW-1:0] s2_lhs_q, s2_rhs_q;
  logic                    s2_neg_q;
  logic                    s2_vld_q;

  always_comb begin
    lhs_d = s1_dxp_q * s1_dy_q;
    rhs_d = s1_dxe_q * s1_dyp_q;
  end

  // stage 3 compare, direction flipped for descending edges
  logic edge_hit;
  logic parity_q;

  assign edge_hit = s2_neg_q ? (s2_rhs_q < s2_lhs_q) : (s2_lhs_q < s2_rhs_q);

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.vld) begin
      xj_q <= xi;
      yj_q <= yi;
    end
    s1_dxp_q <= dxp_d;
    s1_dy_q  <= dy_d;
    s1_dxe_q <= dxe_d;
    s1_dyp_q <= dyp_d;
    s2_lhs_q <= lhs_d;
    s2_rhs_q <= rhs_d;
    s2_neg_q <= s1_dy_q[DiffW-1];
  end

  // valid chain and parity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      parity_q <= 1'b0;
    end else begin
      s1_vld_q <= ctrl_i.vld && !ctrl_i.prime && straddle_d;
      s2_vld_q <= s1_vld_q;
      if (ctrl_i.clear) begin
        parity_q <= 1'b0;
      end else if (s2_vld_q && edge_hit) begin
        parity_q <= !parity_q;
      end
    end
  end

  assign stat_o.busy   = s1_vld_q || s2_vld_q;
  assign stat_o.parity = parity_q;

endmodule
